[hdl/rsi_pkg.sv]
package rsi_pkg;

  // Field widths of the ports.
  localparam int unsigned CoordW = 32;
  localparam int unsigned RadW   = 31;

  // Internal widths, chosen so that every intermediate value is exact.
  localparam int unsigned OcW   = 33;   // origin - centre
  localparam int unsigned AW    = 64;   // |dir|^2
  localparam int unsigned HbW   = 67;   // signed half_b
  localparam int unsigned CW    = 67;   // signed c
  localparam int unsigned MagW  = 66;   // magnitudes of half_b and c
  localparam int unsigned DiscW = 132;  // discriminant magnitude
  localparam int unsigned RootW = DiscW / 2;
  localparam int unsigned NmW   = 67;   // magnitude of -half_b - root
  localparam int unsigned QW    = 32;   // quotient bits worked out

  typedef enum logic [1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_CENTER_Z = 2'd2,
    CFG_RADIUS   = 2'd3
  } cfg_reg_e;

  // Control that travels alongside each request through the pipeline.
  typedef struct packed {
    logic vld;
    logic miss;
  } ctl_t;

endpackage

[hdl/ray_sphere_intersect.sv]
// Ray against sphere intersection, fully pipelined.
//
// Rays arrive on the slave stream (s_axis_*), one request per ray, and each
// ray produces exactly one result on the master stream (m_axis_*): tuser
// carries the hit flag, tdata the distance to the nearer root in signed
// fixed point, or -1.0 on a miss. The sphere centre and radius are held in
// four registers written through the cfg_* channel, which is always ready;
// they should only be changed while no ray is in flight.
//
// A ray passes in order through the front end, which forms the quadratic and
// its discriminant, the square root, which works out the root a bit at a time,
// the stages that form and scale the numerator, the divider, which works out
// the quotient a bit at a time, and the output register. Throughput is one ray
// per cycle while the receiver does not stall, as no stage of the pipeline iterates.
//
// Reset clears every valid bit and loads the centre (0, 0, 0) and radius
// 1.0. When the receiver stalls with a result waiting, the whole pipeline
// holds and s_axis_tready drops; nothing is lost or repeated, and the
// pipeline keeps filling while the output register is empty.
module ray_sphere_intersect #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, 32 bits each
  input  logic [191:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit_distance
  output logic [31:0]  m_axis_tdata,
  // hit
  output logic         m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  localparam int unsigned CW = rsi_pkg::CoordW;

  logic [2:0][CW-1:0]         center_q;
  logic [rsi_pkg::RadW-1:0]   radius_q;
  logic                       en;
  logic [2:0][CW-1:0]         origin, dir;

  rsi_pkg::ctl_t                  front_ctl, sqrt_ctl;
  logic signed [rsi_pkg::HbW-1:0] front_hb, sqrt_hb;
  logic [rsi_pkg::AW-1:0]         front_a, sqrt_a;
  logic [rsi_pkg::DiscW-1:0]      front_disc;
  logic [rsi_pkg::RootW-1:0]      sqrt_root;

  // Configuration registers; the channel never pushes back.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= '0;
      radius_q <= rsi_pkg::RadW'(32'h0001_0000);
    end else if (cfg_valid_i) begin
      unique case (rsi_pkg::cfg_reg_e'(cfg_index_i))
        rsi_pkg::CFG_CENTER_X: center_q[0] <= cfg_data_i;
        rsi_pkg::CFG_CENTER_Y: center_q[1] <= cfg_data_i;
        rsi_pkg::CFG_CENTER_Z: center_q[2] <= cfg_data_i;
        rsi_pkg::CFG_RADIUS:   radius_q    <= cfg_data_i[rsi_pkg::RadW-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves as one whenever the output register is free or
  // being emptied in this cycle.
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  for (genvar i = 0; i < 3; i++) begin : g_unpack
    assign origin[i] = s_axis_tdata[i*CW +: CW];
    assign dir[i]    = s_axis_tdata[(i+3)*CW +: CW];
  end

  rsi_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (s_axis_tvalid),
    .origin_i (origin),
    .dir_i    (dir),
    .center_i (center_q),
    .radius_i (radius_q),
    .ctl_o    (front_ctl),
    .hb_o     (front_hb),
    .a_o      (front_a),
    .disc_o   (front_disc)
  );

  rsi_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (front_ctl),
    .hb_i   (front_hb),
    .a_i    (front_a),
    .disc_i (front_disc),
    .ctl_o  (sqrt_ctl),
    .hb_o   (sqrt_hb),
    .a_o    (sqrt_a),
    .root_o (sqrt_root)
  );

  rsi_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (sqrt_ctl),
    .hb_i   (sqrt_hb),
    .a_i    (sqrt_a),
    .root_i (sqrt_root),
    .vld_o  (m_axis_tvalid),
    .hit_o  (m_axis_tuser),
    .dist_o (m_axis_tdata)
  );

endmodule

[hdl/rsi_front.sv]
module rsi_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 vld_i,
  input  logic [2:0][rsi_pkg::CoordW-1:0]      origin_i,
  input  logic [2:0][rsi_pkg::CoordW-1:0]      dir_i,
  input  logic [2:0][rsi_pkg::CoordW-1:0]      center_i,
  input  logic [rsi_pkg::RadW-1:0]             radius_i,
  output rsi_pkg::ctl_t                        ctl_o,
  output logic signed [rsi_pkg::HbW-1:0]       hb_o,
  output logic [rsi_pkg::AW-1:0]               a_o,
  output logic [rsi_pkg::DiscW-1:0]            disc_o
);

  localparam int unsigned OdW = 65;
  localparam int unsigned OoW = 65;
  localparam int unsigned RrW = 2 * rsi_pkg::RadW;
  localparam int unsigned HalfW = rsi_pkg::MagW / 2;

  logic [6:0] vld_q;

  // Stage 1: offset from the centre.
  logic signed [rsi_pkg::OcW-1:0]    oc_q [3];
  logic signed [rsi_pkg::CoordW-1:0] d_q  [3];
  // Stage 2: products.
  logic [63:0]              dd_q [3];
  logic signed [OdW-1:0]    od_q [3];
  logic [OoW-1:0]           oo_q [3];
  logic [RrW-1:0]           rr_q;
  // Stage 3: sums.
  logic [rsi_pkg::AW-1:0]        a3_q;
  logic signed [rsi_pkg::HbW-1:0] hb3_q;
  logic signed [rsi_pkg::CW-1:0]  c3_q;
  // Stage 4: magnitudes.
  logic [rsi_pkg::AW-1:0]         a4_q;
  logic signed [rsi_pkg::HbW-1:0] hb4_q;
  logic [rsi_pkg::MagW-1:0]       hbm_q, cm_q;
  logic                           cneg4_q;
  // Stage 5: partial products.
  logic [rsi_pkg::AW-1:0]         a5_q;
  logic signed [rsi_pkg::HbW-1:0] hb5_q;
  logic                           cneg5_q;
  logic [2*HalfW-1:0]             hll_q, hlh_q, hhh_q;
  logic [64:0]                    pll_q, plh_q, phl_q, phh_q;
  // Stage 6: half_b squared and the product a*c.
  logic [rsi_pkg::AW-1:0]         a6_q;
  logic signed [rsi_pkg::HbW-1:0] hb6_q;
  logic                           cneg6_q;
  logic [rsi_pkg::DiscW-1:0]      hb2_q, ac_q;
  // Stage 7: discriminant.
  logic                           miss_q;

  logic signed [OdW-1:0] od_d [3];
  logic signed [OoW-1:0] oo_d [3];
  logic signed [63:0]    dd_d [3];
  logic [OoW:0]          oosum_d;
  logic                  disc_neg_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      od_d[i] = OdW'(oc_q[i]) * OdW'(d_q[i]);
      oo_d[i] = OoW'(oc_q[i]) * OoW'(oc_q[i]);
      dd_d[i] = 64'(d_q[i]) * 64'(d_q[i]);
    end
    oosum_d = (OoW+1)'(oo_q[0]) + (OoW+1)'(oo_q[1]) + (OoW+1)'(oo_q[2]);
    disc_neg_d = !cneg6_q && (hb2_q < ac_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[5:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        oc_q[i] <= $signed({origin_i[i][rsi_pkg::CoordW-1], origin_i[i]})
                 - $signed({center_i[i][rsi_pkg::CoordW-1], center_i[i]});
        d_q[i]  <= $signed(dir_i[i]);
        dd_q[i] <= dd_d[i];
        od_q[i] <= od_d[i];
        oo_q[i] <= oo_d[i];
      end
      rr_q <= RrW'(radius_i) * RrW'(radius_i);

      a3_q  <= dd_q[0] + dd_q[1] + dd_q[2];
      hb3_q <= rsi_pkg::HbW'(od_q[0]) + rsi_pkg::HbW'(od_q[1]) + rsi_pkg::HbW'(od_q[2]);
      c3_q  <= $signed({1'b0, oosum_d}) - $signed({5'd0, rr_q});

      a4_q    <= a3_q;
      hb4_q   <= hb3_q;
      hbm_q   <= hb3_q[rsi_pkg::HbW-1] ? rsi_pkg::MagW'(-hb3_q) : rsi_pkg::MagW'(hb3_q);
      cm_q    <= c3_q[rsi_pkg::CW-1] ? rsi_pkg::MagW'(-c3_q) : rsi_pkg::MagW'(c3_q);
      cneg4_q <= c3_q[rsi_pkg::CW-1];

      a5_q    <= a4_q;
      hb5_q   <= hb4_q;
      cneg5_q <= cneg4_q;
      hll_q   <= (2*HalfW)'(hbm_q[HalfW-1:0]) * (2*HalfW)'(hbm_q[HalfW-1:0]);
      hlh_q   <= (2*HalfW)'(hbm_q[HalfW-1:0]) * (2*HalfW)'(hbm_q[2*HalfW-1:HalfW]);
      hhh_q   <= (2*HalfW)'(hbm_q[2*HalfW-1:HalfW]) * (2*HalfW)'(hbm_q[2*HalfW-1:HalfW]);
      pll_q   <= 65'(a4_q[31:0])  * 65'(cm_q[HalfW-1:0]);
      plh_q   <= 65'(a4_q[31:0])  * 65'(cm_q[2*HalfW-1:HalfW]);
      phl_q   <= 65'(a4_q[63:32]) * 65'(cm_q[HalfW-1:0]);
      phh_q   <= 65'(a4_q[63:32]) * 65'(cm_q[2*HalfW-1:HalfW]);

      a6_q    <= a5_q;
      hb6_q   <= hb5_q;
      cneg6_q <= cneg5_q;
      hb2_q   <= (rsi_pkg::DiscW'(hhh_q) << (2*HalfW))
               + (rsi_pkg::DiscW'(hlh_q) << (HalfW+1))
               + rsi_pkg::DiscW'(hll_q);
      ac_q    <= (rsi_pkg::DiscW'(phh_q) << (32+HalfW))
               + (rsi_pkg::DiscW'(phl_q) << 32)
               + (rsi_pkg::DiscW'(plh_q) << HalfW)
               + rsi_pkg::DiscW'(pll_q);

      a_o    <= a6_q;
      hb_o   <= hb6_q;
      disc_o <= cneg6_q ? (hb2_q + ac_q) : (hb2_q - ac_q);
      miss_q <= (a6_q == '0) || disc_neg_d;
    end
  end

  assign ctl_o = '{vld: vld_q[6], miss: miss_q};

endmodule

[hdl/rsi_sqrt.sv]
module rsi_sqrt (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  rsi_pkg::ctl_t                  ctl_i,
  input  logic signed [rsi_pkg::HbW-1:0] hb_i,
  input  logic [rsi_pkg::AW-1:0]         a_i,
  input  logic [rsi_pkg::DiscW-1:0]      disc_i,
  output rsi_pkg::ctl_t                  ctl_o,
  output logic signed [rsi_pkg::HbW-1:0] hb_o,
  output logic [rsi_pkg::AW-1:0]         a_o,
  output logic [rsi_pkg::RootW-1:0]      root_o
);

  localparam int unsigned N = rsi_pkg::RootW;
  localparam int unsigned TW = rsi_pkg::DiscW + 1;

  logic                           vld_q  [N];
  logic                           miss_q [N];
  logic signed [rsi_pkg::HbW-1:0] hb_q   [N];
  logic [rsi_pkg::AW-1:0]         a_q    [N];
  logic [rsi_pkg::DiscW-1:0]      rem_q  [N];
  logic [N-1:0]                   root_q [N];

  // One result bit per stage, most significant first: the bit is kept when
  // (root + 2^k)^2 still fits under the radicand.
  for (genvar s = 0; s < N; s++) begin : g_stage
    localparam int unsigned K = N - 1 - s;
    logic                           vld_in, miss_in;
    logic signed [rsi_pkg::HbW-1:0] hb_in;
    logic [rsi_pkg::AW-1:0]         a_in;
    logic [rsi_pkg::DiscW-1:0]      rem_in;
    logic [N-1:0]                   root_in;
    logic [TW-1:0]                  trial;
    logic                           take;

    if (s == 0) begin : g_first
      assign vld_in  = ctl_i.vld;
      assign miss_in = ctl_i.miss;
      assign hb_in   = hb_i;
      assign a_in    = a_i;
      assign rem_in  = disc_i;
      assign root_in = '0;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign miss_in = miss_q[s-1];
      assign hb_in   = hb_q[s-1];
      assign a_in    = a_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
    end

    assign trial = (TW'(root_in) << (K + 1)) | (TW'(1) << (2 * K));
    assign take  = TW'(rem_in) >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        miss_q[s] <= miss_in;
        hb_q[s]   <= hb_in;
        a_q[s]    <= a_in;
        rem_q[s]  <= take ? rsi_pkg::DiscW'(TW'(rem_in) - trial) : rem_in;
        root_q[s] <= take ? (root_in | (N'(1) << K)) : root_in;
      end
    end
  end

  assign ctl_o  = '{vld: vld_q[N-1], miss: miss_q[N-1]};
  assign hb_o   = hb_q[N-1];
  assign a_o    = a_q[N-1];
  assign root_o = root_q[N-1];

endmodule

[hdl/rsi_div.sv]
module rsi_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  rsi_pkg::ctl_t                  ctl_i,
  input  logic signed [rsi_pkg::HbW-1:0] hb_i,
  input  logic [rsi_pkg::AW-1:0]         a_i,
  input  logic [rsi_pkg::RootW-1:0]      root_i,
  output logic                           vld_o,
  output logic                           hit_o,
  output logic [rsi_pkg::CoordW-1:0]     dist_o
);

  localparam int unsigned QW    = rsi_pkg::QW;
  localparam int unsigned AW    = rsi_pkg::AW;
  localparam int unsigned NW    = rsi_pkg::NmW + 1;
  localparam int unsigned NumW  = rsi_pkg::NmW + FRAC_BITS;
  localparam int unsigned CmpW  = (NumW > AW + QW) ? NumW : AW + QW;
  localparam logic [rsi_pkg::CoordW-1:0] MissDist =
    ~((rsi_pkg::CoordW'(1) << FRAC_BITS) - rsi_pkg::CoordW'(1));
  localparam logic [QW-1:0] NegLimit = {1'b1, {(QW-1){1'b0}}};
  localparam logic [QW-1:0] PosLimit = {1'b0, {(QW-1){1'b1}}};

  // Stage A: numerator -half_b - root, as sign and magnitude.
  logic                     vA_q, missA_q, nnegA_q;
  logic [rsi_pkg::NmW-1:0]  nmA_q;
  logic [AW-1:0]            aA_q;
  logic signed [NW-1:0]     n_d;
  // Stage B: scaled numerator, overflow test and first partial remainder.
  logic                     vB_q, missB_q, nnegB_q, bigB_q;
  logic [AW-1:0]            aB_q, remB_q;
  logic [QW-1:0]            loB_q;
  logic [CmpW-1:0]          num_d;
  // Long division, one quotient bit per stage.
  logic                     vld_q  [QW];
  logic                     miss_q [QW];
  logic                     nneg_q [QW];
  logic                     big_q  [QW];
  logic [AW-1:0]            a_q    [QW];
  logic [AW-1:0]            rem_q  [QW];
  logic [QW-1:0]            lo_q   [QW];
  logic [QW-1:0]            quo_q  [QW];
  // Output register.
  logic                     vo_q, hit_q;
  logic [rsi_pkg::CoordW-1:0] dist_q, dist_d;

  assign n_d   = -NW'(hb_i) - $signed({2'b00, root_i});
  assign num_d = CmpW'({nmA_q, {FRAC_BITS{1'b0}}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vA_q <= 1'b0;
      vB_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      vA_q <= ctl_i.vld;
      vB_q <= vA_q;
      vo_q <= vld_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      missA_q <= ctl_i.miss;
      aA_q    <= a_i;
      nnegA_q <= n_d[NW-1];
      nmA_q   <= n_d[NW-1] ? rsi_pkg::NmW'(-n_d) : rsi_pkg::NmW'(n_d);

      missB_q <= missA_q;
      nnegB_q <= nnegA_q;
      aB_q    <= aA_q;
      bigB_q  <= num_d >= (CmpW'(aA_q) << QW);
      remB_q  <= AW'(num_d >> QW);
      loB_q   <= num_d[QW-1:0];
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int unsigned B = QW - 1 - s;
    logic          vld_in, miss_in, nneg_in, big_in;
    logic [AW-1:0] a_in, rem_in;
    logic [QW-1:0] lo_in, quo_in;
    logic [AW:0]   trial;
    logic          take;

    if (s == 0) begin : g_first
      assign vld_in  = vB_q;
      assign miss_in = missB_q;
      assign nneg_in = nnegB_q;
      assign big_in  = bigB_q;
      assign a_in    = aB_q;
      assign rem_in  = remB_q;
      assign lo_in   = loB_q;
      assign quo_in  = '0;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign miss_in = miss_q[s-1];
      assign nneg_in = nneg_q[s-1];
      assign big_in  = big_q[s-1];
      assign a_in    = a_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign lo_in   = lo_q[s-1];
      assign quo_in  = quo_q[s-1];
    end

    assign trial = {rem_in, lo_in[B]};
    assign take  = trial >= {1'b0, a_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        miss_q[s] <= miss_in;
        nneg_q[s] <= nneg_in;
        big_q[s]  <= big_in;
        a_q[s]    <= a_in;
        lo_q[s]   <= lo_in;
        rem_q[s]  <= take ? AW'(trial - {1'b0, a_in}) : trial[AW-1:0];
        quo_q[s]  <= take ? (quo_in | (QW'(1) << B)) : quo_in;
      end
    end
  end

  // Sign and saturation of the quotient, or the miss distance on a miss.
  always_comb begin
    if (miss_q[QW-1]) begin
      dist_d = MissDist;
    end else if (nneg_q[QW-1]) begin
      dist_d = (big_q[QW-1] || quo_q[QW-1] > NegLimit) ? NegLimit : -quo_q[QW-1];
    end else begin
      dist_d = (big_q[QW-1] || quo_q[QW-1] > PosLimit) ? PosLimit : quo_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q  <= !miss_q[QW-1];
      dist_q <= dist_d;
    end
  end

  assign vld_o  = vo_q;
  assign hit_o  = hit_q;
  assign dist_o = dist_q;

endmodule

[hdl/rsi_checker.sv]
module rsi_checker #(
  parameter int FRAC_BITS = 16
) (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [191:0] s_axis_tdata,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [31:0]  m_axis_tdata,
  input logic         m_axis_tuser,
  input logic         cfg_valid_i,
  input logic         cfg_ready_o,
  input logic [1:0]   cfg_index_i,
  input logic [31:0]  cfg_data_i
);

  localparam logic [31:0] MissDist = ~((32'd1 << FRAC_BITS) - 32'd1);

  // A stalled result must stay put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // A miss always reports a distance of -1.0.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == MissDist)
    else $error("miss with wrong distance");

  // Input is only held off while a result waits on a stalled receiver.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input blocked without an output stall");

  // Configuration writes are never refused.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind ray_sphere_intersect rsi_checker #(.FRAC_BITS(FRAC_BITS)) u_rsi_checker (.*);
